### src/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helper functions of the URL percent
// decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Most results one input byte can release
    localparam int MAX_RES = 3;

    // Result queue geometry
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Fill levels up to which the input may take a byte: with and without
    // a byte still in the input stage
    localparam logic [Q_CW-1:0] RDY_LIM_BUSY = Q_CW'(Q_DEPTH - 2 * MAX_RES);
    localparam logic [Q_CW-1:0] RDY_LIM_IDLE = Q_CW'(Q_DEPTH - MAX_RES);

    // Escape sequence progress
    typedef enum logic [1:0] {
        PEND_IDLE,
        PEND_PCT,
        PEND_HEX
    } t_pend;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_result;

    // Results released by one input byte, slot 0 first
    typedef struct packed {
        logic [1:0]                 count;
        t_result [MAX_RES-1:0]      res;
    } t_burst;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Digits keep their low nibble; letters of either case add nine
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

### src/upd_if.sv
// ----------------------------------------------------------------------------
// upd_if
// Valid/ready channels of the URL percent decoder: encoded input bytes,
// decoded results and the configuration write.
// ----------------------------------------------------------------------------
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;

    modport source (output valid, output out_byte, output run_last,
                    output string_done, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_done, output ready);
endinterface

interface upd_cfg_if;
    logic valid;
    logic ready;
    logic plus_to_space;

    modport source (output valid, output plus_to_space, input ready);
    modport sink   (input valid, input plus_to_space, output ready);
endinterface

### src/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Input stage and escape decoder: registers one encoded byte, then turns it
// with the held escape state into zero to three results for the queue.
// ----------------------------------------------------------------------------
module upd_decode
    import upd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    upd_in_if.sink          i_in,
    input  logic            i_plus_to_space,
    input  logic [Q_CW-1:0] i_q_count,
    output t_burst          o_burst
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    t_pend      r_pend;
    t_pend      n_pend;
    logic [7:0] r_held;
    logic [7:0] n_held;

    logic       in_accept;
    logic       hold_pct;
    logic [7:0] fresh_byte;
    logic [1:0] res_n;
    logic [7:0] res_byte [MAX_RES];

    // Take a byte only when the queue can absorb a worst-case burst
    assign i_in.ready = r_valid ? (i_q_count <= RDY_LIM_BUSY)
                                : (i_q_count <= RDY_LIM_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    // Input stage: drains every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= in_accept;
        end
        if (in_accept) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.end_of_string;
        end
    end

    // Fresh decode of the staged byte
    assign hold_pct   = (r_byte == CH_PERCENT) && !r_last;
    assign fresh_byte = ((r_byte == CH_PLUS) && i_plus_to_space) ? CH_SPACE : r_byte;

    // Escape decoder
    always_comb begin
        n_pend      = r_pend;
        n_held      = r_held;
        res_n       = 2'd0;
        res_byte[0] = fresh_byte;
        res_byte[1] = fresh_byte;
        res_byte[2] = fresh_byte;
        case (r_pend)
            PEND_PCT: begin
                if (is_hex(r_byte) && !r_last) begin
                    n_held = r_byte;
                    n_pend = PEND_HEX;
                end else begin
                    res_byte[0] = CH_PERCENT;
                    n_pend      = hold_pct ? PEND_PCT : PEND_IDLE;
                    res_n       = hold_pct ? 2'd1 : 2'd2;
                end
            end
            PEND_HEX: begin
                if (is_hex(r_byte)) begin
                    res_byte[0] = {hex_val(r_held), hex_val(r_byte)};
                    res_n       = 2'd1;
                    n_pend      = PEND_IDLE;
                end else begin
                    res_byte[0] = CH_PERCENT;
                    res_byte[1] = r_held;
                    n_pend      = hold_pct ? PEND_PCT : PEND_IDLE;
                    res_n       = hold_pct ? 2'd2 : 2'd3;
                end
            end
            default: begin
                n_pend = hold_pct ? PEND_PCT : PEND_IDLE;
                res_n  = hold_pct ? 2'd0 : 2'd1;
            end
        endcase
    end

    // Pack the burst and flag its final result
    always_comb begin
        o_burst.count = r_valid ? res_n : 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            o_burst.res[k].out_byte    = res_byte[k];
            o_burst.res[k].run_last    = (2'(k + 1) == res_n);
            o_burst.res[k].string_done = (2'(k + 1) == res_n) && r_last;
        end
    end

    // Escape state advances only on a staged byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_IDLE;
            r_held <= 8'd0;
        end else if (r_valid) begin
            r_pend <= n_pend;
            r_held <= n_held;
        end
    end

    // The end of a string always leaves nothing held
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |=> (r_pend == PEND_IDLE))
        else $error("escape state survives end of string");

    // A final byte always releases at least one result
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (o_burst.count != 2'd0))
        else $error("final byte released no result");

    // No burst without a staged byte
    a_burst_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_burst.count != 2'd0) |-> r_valid)
        else $error("burst without staged byte");

endmodule

### src/upd_out_queue.sv
// ----------------------------------------------------------------------------
// upd_out_queue
// Result queue: takes a burst of up to three results per cycle and delivers
// them one per transaction on the output channel.
// ----------------------------------------------------------------------------
module upd_out_queue
    import upd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_burst          i_burst,
    upd_out_if.source       o_out,
    output logic [Q_CW-1:0] o_count
);

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            pop;

    // Present the head entry
    assign o_out.valid       = (r_count != '0);
    assign o_out.out_byte    = r_mem[r_rptr].out_byte;
    assign o_out.run_last    = r_mem[r_rptr].run_last;
    assign o_out.string_done = r_mem[r_rptr].string_done;
    assign pop               = o_out.valid && o_out.ready;
    assign o_count           = r_count;

    assign n_count = r_count + Q_CW'(i_burst.count) - Q_CW'(pop);

    // Write the burst in order behind the tail
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_burst.count) begin
                r_mem[r_wptr + Q_AW'(k)] <= i_burst.res[k];
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + Q_AW'(i_burst.count);
            r_rptr  <= r_rptr + Q_AW'(pop);
            r_count <= n_count;
        end
    end

    // An incoming burst always fits
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(i_burst.count)) <= Q_DEPTH)
        else $error("result queue overflow");

    // Fill level tracks the pointer distance
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != Q_CW'(Q_DEPTH)) |-> (Q_AW'(r_wptr - r_rptr) == r_count[Q_AW-1:0]))
        else $error("queue count and pointers disagree");

    // Last entry taken with nothing arriving empties the queue
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_count == Q_CW'(1)) && (i_burst.count == 2'd0)) |=> !o_out.valid)
        else $error("queue not empty after final pop");

endmodule

### src/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming URL percent decoder with form or raw handling of the plus sign.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per cycle and delivers decoded bytes on
// the output channel. A percent sign and a first hex digit release nothing; a
// complete escape releases one byte, and a broken escape releases the percent
// sign, any held digit and the fresh decode of the current byte, up to three
// results, which an eight-entry queue delivers one per cycle while the output
// is ready. The input stays ready while the queue can take a worst-case burst
// behind the byte in flight, so with one result per byte the rate is one byte
// per cycle; bursts and output backpressure lower it. The plus_to_space
// register (reset 1) is written through the always-ready configuration
// channel; the user must write it only while idle; the block does not check.
// ----------------------------------------------------------------------------
module url_percent_decoder_top
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    upd_cfg_if.sink    i_cfg,
    upd_in_if.sink     i_in,
    upd_out_if.source  o_out
);

    logic            r_plus_to_space;
    t_burst          burst;
    logic [Q_CW-1:0] q_count;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_to_space <= 1'b1;
        end else if (i_cfg.valid) begin
            r_plus_to_space <= i_cfg.plus_to_space;
        end
    end

    upd_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_plus_to_space(r_plus_to_space),
        .i_q_count      (q_count),
        .o_burst        (burst)
    );

    upd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .o_out   (o_out),
        .o_count (q_count)
    );

endmodule

### verif/url_percent_decoder_top_test.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top_test
// Self-checking testbench of the URL percent decoder. Encoded strings, both
// hand-picked and random, are sent through the input channel. A behavioral
// decoder predicts the decoded bytes of every accepted transaction, and each
// output transaction is compared field by field with the oldest prediction.
// Both channels idle at random. The output is once held off long enough to
// stall the input. Form and raw handling of the plus sign are both covered.
// ----------------------------------------------------------------------------
module url_percent_decoder_top_test;
    import upd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Hex digit ranges
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES   = 16;

    logic i_clk;
    logic i_rst_n;

    upd_cfg_if cfg_if ();
    upd_in_if  in_if ();
    upd_out_if out_if ();

    url_percent_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Decoder state as the checker sees it
    t_pend      esc_state;
    logic [7:0] esc_digit;
    logic       form_mode;
    t_result    decoded_q[$];

    int  errors;
    int  cycle_cnt;
    bit  idle_en;
    bit  hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d decoded bytes outstanding", $time,
                         decoded_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic is_hex_digit(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_NINE) v = c - CH_ZERO;
        else if (c >= CH_LO_A) v = c - CH_LO_A + 8'd10;
        else v = c - CH_UP_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic void push_decoded(input logic [7:0] b);
        t_result r;
        r.out_byte    = b;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        decoded_q.push_back(r);
    endfunction

    // Decode a byte with no escape in progress
    function automatic void decode_plain(input logic [7:0] b, input logic eos);
        if (b == CH_PERCENT && !eos) begin
            esc_state = PEND_PCT;
            esc_digit = 8'h00;
        end else if (b == CH_PLUS && form_mode) begin
            push_decoded(CH_SPACE);
        end else begin
            push_decoded(b);
        end
    endfunction

    // Advance the decoder by one encoded byte and queue what it releases
    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        int      before_cnt;
        t_result r;
        before_cnt = decoded_q.size();
        case (esc_state)
            PEND_PCT: begin
                if (is_hex_digit(b) && !eos) begin
                    esc_digit = b;
                    esc_state = PEND_HEX;
                end else begin
                    esc_state = PEND_IDLE;
                    push_decoded(CH_PERCENT);
                    decode_plain(b, eos);
                end
            end
            PEND_HEX: begin
                esc_state = PEND_IDLE;
                if (is_hex_digit(b)) begin
                    push_decoded({digit_value(esc_digit), digit_value(b)});
                end else begin
                    push_decoded(CH_PERCENT);
                    push_decoded(esc_digit);
                    decode_plain(b, eos);
                end
                esc_digit = 8'h00;
            end
            default: begin
                esc_state = PEND_IDLE;
                decode_plain(b, eos);
            end
        endcase
        // Flag the last byte released by this transaction
        if (decoded_q.size() > before_cnt) begin
            r = decoded_q.pop_back();
            r.run_last    = 1'b1;
            r.string_done = eos;
            decoded_q.push_back(r);
        end
    endfunction

    // Track configuration, predict on input, check on output
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            esc_state = PEND_IDLE;
            esc_digit = 8'h00;
            form_mode = 1'b1;
        end else begin
            if (cfg_if.valid && cfg_if.ready) form_mode = cfg_if.plus_to_space;
            if (in_if.valid && in_if.ready) decode_byte(in_if.in_byte, in_if.end_of_string);
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result out_byte=%h run_last=%b string_done=%b",
                             $time, out_if.out_byte, out_if.run_last, out_if.string_done);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.out_byte, out_if.out_byte);
                        errors++;
                    end
                    if (out_if.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.run_last, out_if.run_last);
                        errors++;
                    end
                    if (out_if.string_done !== want.string_done) begin
                        $display("%0t: string_done expected %b actual %b", $time,
                                 want.string_done, out_if.string_done);
                        errors++;
                    end
                end
            end
        end
    end

    // Output side: random stall bursts and the long hold-off
    initial begin
        int hold_left;
        int stall_left;
        hold_left    = 0;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                stall_left   = $urandom_range(1, 7) - 1;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // Send one encoded byte, with an optional idle burst before it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.in_byte       = b;
        in_if.end_of_string = eos;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // Drop valid, wait for every decoded byte, then let the pipeline settle
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_plus_to_space(input logic v);
        @(negedge i_clk);
        cfg_if.valid         = 1'b1;
        cfg_if.plus_to_space = v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [7:0] random_hex_digit();
        int d;
        d = $urandom_range(0, 21);
        if (d < 10) return CH_ZERO + 8'(d);
        else if (d < 16) return CH_LO_A + 8'(d - 10);
        else return CH_UP_A + 8'(d - 16);
    endfunction

    // Random strings built mostly from escapes, with broken escapes and noise
    task automatic send_random_text(input int n_items);
        logic [7:0] text[$];
        int         sent;
        int         len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            text.delete();
            while (text.size() < len) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        text.push_back(CH_PERCENT);
                        text.push_back(random_hex_digit());
                        text.push_back(random_hex_digit());
                    end
                    4: text.push_back(CH_PLUS);
                    5: begin
                        // mostly a broken escape: the next byte is decoded afresh
                        text.push_back(CH_PERCENT);
                        if ($urandom_range(0, 1)) text.push_back(random_hex_digit());
                        case ($urandom_range(0, 2))
                            0: text.push_back(CH_PERCENT);
                            1: text.push_back(CH_PLUS);
                            default: text.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                    6, 7: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    default: text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            foreach (text[i]) send_byte(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    // Escapes in both cases, broken escapes, flush at end of string, byte extremes
    task automatic test_directed_form();
        send_text("%41");
        send_text("%6a%Ff");
        send_text("%4+");
        send_text("%%2b");
        send_text("%");
        send_text("%c");
        send_byte(8'h00, 1'b0);
        send_byte(CH_PERCENT, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle(SETTLE_CYCLES);
    endtask

    // Plus sign passes through in raw mode
    task automatic test_directed_raw();
        write_plus_to_space(1'b0);
        send_text("+%2+");
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_random_form();
        write_plus_to_space(1'b1);
        send_random_text(70);
        wait_idle(SETTLE_CYCLES);
    endtask

    // Hold the output off so the result queue fills and the input stalls
    task automatic test_output_hold();
        hold_req = 1'b1;
        send_random_text(40);
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_random_raw();
        write_plus_to_space(1'b0);
        send_random_text(70);
        wait_idle(SETTLE_CYCLES);
    endtask

    // Full rate on both sides, mode switched between passes
    task automatic test_streaming();
        idle_en = 1'b0;
        write_plus_to_space(1'b1);
        send_random_text(30);
        wait_idle(SETTLE_CYCLES);
        write_plus_to_space(1'b0);
        send_random_text(30);
    endtask

    initial begin
        errors               = 0;
        idle_en              = 1'b1;
        hold_req             = 1'b0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.in_byte        = 8'h00;
        in_if.end_of_string  = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.plus_to_space = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_form();
        test_directed_raw();
        test_random_form();
        test_output_hold();
        test_random_raw();
        test_streaming();
        wait_idle(END_CYCLES);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
src/upd_pkg.sv
src/upd_if.sv
src/upd_decode.sv
src/upd_out_queue.sv
src/url_percent_decoder_top.sv
verif/url_percent_decoder_top_test.sv
